// ----- sv/htrcg_pkg.sv -----
// ----------------------------------------------------------------------------
// htrcg_pkg
// shared types, constants and the arithmetic helper of the hsi to rgbw converter
// ----------------------------------------------------------------------------
package htrcg_pkg;

	// angle constants in sixteenths of a degree
	localparam logic [12:0] TURN_STEPS    = 13'd5760;
	localparam logic [11:0] HALF_STEPS    = 12'd2880;
	localparam logic [12:0] QUARTER_STEPS = 13'd1440;
	localparam logic [12:0] RED_STEPS     = 13'd155;
	localparam logic [12:0] GREEN_STEPS   = 13'd2299;
	localparam logic [12:0] BLUE_STEPS    = 13'd4249;

	// bhaskara denominator 40500 * 16 * 16
	localparam logic [23:0] BHASK_DEN = 24'd10368000;

	// quotient bits and operand width of the pipelined divider
	localparam int Q_W   = 17;
	localparam int DIV_W = 30;

	localparam int DUTY_W     = 16;
	localparam int PIPE_DEPTH = 3 + Q_W + 3 + Q_W + 1 + 4;

	// register indexes
	localparam logic [2:0] REG_DUTY_RES   = 3'd0;
	localparam logic [2:0] REG_RED_GAIN   = 3'd1;
	localparam logic [2:0] REG_GREEN_GAIN = 3'd2;
	localparam logic [2:0] REG_BLUE_GAIN  = 3'd3;
	localparam logic [2:0] REG_WHITE_GAIN = 3'd4;

	typedef enum logic [1:0] {
		EDGE_RG = 2'd0,
		EDGE_GB = 2'd1,
		EDGE_BR = 2'd2
	} edge_t;

	typedef enum logic [1:0] {
		T_DIV  = 2'd0,
		T_ZERO = 2'd1,
		T_FULL = 2'd2
	} tcode_t;

	// first primary of each edge and edge direction, signed q1.14
	localparam logic signed [14:0] PA_U [3] = '{15'sd5098, -15'sd2342, -15'sd454};
	localparam logic signed [14:0] PA_V [3] = '{15'sd868, 15'sd1721, -15'sd5868};
	localparam logic signed [14:0] ED_U [3] = '{-15'sd7440, 15'sd1888, 15'sd5552};
	localparam logic signed [14:0] ED_V [3] = '{15'sd853, -15'sd7589, 15'sd6736};

	typedef struct packed {
		logic [12:0] hue_angle;
		logic [15:0] saturation_level;
		logic [15:0] intensity_level;
	} hsi_t;

	typedef struct packed {
		logic [15:0] red_duty;
		logic [15:0] green_duty;
		logic [15:0] blue_duty;
		logic [15:0] white_duty;
	} rgbw_t;

	// floor(x / 65535) by reciprocal estimate and one correction step
	function automatic logic [16:0] div_ffff(input logic [31:0] x);
		logic [32:0] sum;
		logic [16:0] q;
		logic [33:0] back;
		logic [33:0] r;
		sum  = {1'b0, x} + {17'd0, x[31:16]};
		q    = sum[32:16];
		back = {1'b0, q, 16'd0} - {17'd0, q};
		r    = {2'b00, x} - back;
		if (r >= 34'd65535) begin
			q = q + 17'd1;
		end
		return q;
	endfunction

endpackage

// ----- sv/htrcg_div.sv -----
// ----------------------------------------------------------------------------
// htrcg_div
// restoring divider, one quotient bit per stage: floor(x * 2^16 / d), x <= d
// ----------------------------------------------------------------------------
module htrcg_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [htrcg_pkg::DIV_W-1:0] dividend,
	input  logic [htrcg_pkg::DIV_W-1:0] divisor,
	output logic [htrcg_pkg::Q_W-1:0]   quotient
);
	import htrcg_pkg::*;

	logic [DIV_W-1:0] rem_s [Q_W];
	logic [DIV_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [DIV_W:0]   trial;
		logic [DIV_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic             ge;

		if (i == 0) begin : g_first
			assign trial  = {1'b0, dividend};
			assign den_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign trial  = {rem_s[i-1], 1'b0};
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign ge = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DIV_W'(trial - {1'b0, den_in}) : trial[DIV_W-1:0];
				den_s[i] <= den_in;
				quo_s[i] <= {quo_in[Q_W-2:0], ge};
			end
		end
	end

	assign quotient = quo_s[Q_W-1];

endmodule

// ----- sv/htrcg_chan.sv -----
// ----------------------------------------------------------------------------
// htrcg_chan
// channel scaler: level * gain / 65535, then * full scale / 65535, saturated
// ----------------------------------------------------------------------------
module htrcg_chan (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] level,
	input  logic [15:0] gain,
	input  logic [15:0] fs,
	output logic [15:0] duty
);
	import htrcg_pkg::*;

	logic [31:0] mul1_s1;
	logic [15:0] gsc_s2;
	logic [31:0] mul2_s3;
	logic [15:0] duty_s4;
	logic [16:0] g_div;
	logic [16:0] d_div;

	assign g_div = div_ffff(mul1_s1);
	assign d_div = div_ffff(mul2_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			mul1_s1 <= 32'(level * gain);
			gsc_s2  <= g_div[15:0];
			mul2_s3 <= 32'(gsc_s2 * fs);
			duty_s4 <= (d_div > {1'b0, fs}) ? fs : d_div[15:0];
		end
	end

	assign duty = duty_s4;

endmodule

// ----- sv/hsi_to_rgbw_cie_gamut_top.sv -----
// ----------------------------------------------------------------------------
// hsi_to_rgbw_cie_gamut_top
// hsi to rgbw pwm duty converter through the lamp gamut in cie u*v* space
// ----------------------------------------------------------------------------
// Takes one hsi transaction per clock while the output is not stalled and
// returns one rgbw duty transaction for each, in order, through two 17-stage
// restoring dividers in series: one pair forms sine and cosine of the hue,
// the other the crossing point on the gamut edge. Backpressure on the output
// stalls the whole pipeline; configuration is expected to change only while
// the pipeline is empty.
module hsi_to_rgbw_cie_gamut_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hsi_valid,
	output logic               hsi_ready,
	input  htrcg_pkg::hsi_t    hsi,
	output logic               rgbw_valid,
	input  logic               rgbw_ready,
	output htrcg_pkg::rgbw_t   rgbw,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);
	import htrcg_pkg::*;

	typedef struct packed {
		logic        ns;
		logic        nc;
		edge_t       edge_sel;
		logic [15:0] is;
		logic [15:0] white;
	} side_a_t;

	typedef struct packed {
		tcode_t      tcode;
		edge_t       edge_sel;
		logic [15:0] is;
		logic [15:0] white;
	} side_b_t;

	// configuration
	logic [4:0]  duty_res_q;
	logic [15:0] red_gain_q, green_gain_q, blue_gain_q, white_gain_q;
	logic [4:0]  res_sat;
	logic [16:0] fs_full;
	logic [15:0] fs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_res_q   <= 5'd8;
			red_gain_q   <= 16'hFFFF;
			green_gain_q <= 16'hFFFF;
			blue_gain_q  <= 16'hFFFF;
			white_gain_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DUTY_RES:   duty_res_q   <= cfg_wdata[4:0];
				REG_RED_GAIN:   red_gain_q   <= cfg_wdata;
				REG_GREEN_GAIN: green_gain_q <= cfg_wdata;
				REG_BLUE_GAIN:  blue_gain_q  <= cfg_wdata;
				REG_WHITE_GAIN: white_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign res_sat = (duty_res_q > 5'(DUTY_W)) ? 5'(DUTY_W) : duty_res_q;
	assign fs_full = (17'd1 << res_sat) - 17'd1;
	assign fs      = fs_full[15:0];

	// pipeline control
	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en         = !vld_q[PIPE_DEPTH-1] || rgbw_ready;
	assign hsi_ready  = en;
	assign rgbw_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], hsi_valid};
		end
	end

	// stage 1: hue reduction, edge pick, i*s and i*(1-s) products
	logic [12:0] h_red, xs, xc;
	logic [13:0] sum_s, sum_c;
	edge_t       edge_c;

	logic [12:0] xs_s1, xc_s1;
	edge_t       edge_s1;
	logic [31:0] prod_is_s1, prod_wh_s1;

	always_comb begin
		h_red = (hsi.hue_angle >= TURN_STEPS) ? 13'(hsi.hue_angle - TURN_STEPS)
			: hsi.hue_angle;
		sum_s = {1'b0, h_red} + {1'b0, RED_STEPS};
		sum_c = {1'b0, h_red} + {1'b0, RED_STEPS} + {1'b0, QUARTER_STEPS};
		xs = (sum_s >= {1'b0, TURN_STEPS}) ? 13'(sum_s - {1'b0, TURN_STEPS}) : sum_s[12:0];
		xc = (sum_c >= {1'b0, TURN_STEPS}) ? 13'(sum_c - {1'b0, TURN_STEPS}) : sum_c[12:0];
		if (xs >= RED_STEPS && xs < GREEN_STEPS) begin
			edge_c = EDGE_RG;
		end else if (xs >= GREEN_STEPS && xs < BLUE_STEPS) begin
			edge_c = EDGE_GB;
		end else begin
			edge_c = EDGE_BR;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s1      <= xs;
			xc_s1      <= xc;
			edge_s1    <= edge_c;
			prod_is_s1 <= 32'(hsi.intensity_level * hsi.saturation_level);
			prod_wh_s1 <= 32'(hsi.intensity_level * (16'hFFFF - hsi.saturation_level));
		end
	end

	// stage 2: fold to half turn, bhaskara product, i*s and white scaling
	logic        ns_c, nc_c;
	logic [11:0] xf_s, xf_c;
	logic [16:0] is_div, wh_div;

	logic        ns_s2, nc_s2;
	logic [21:0] p_s_s2, p_c_s2;
	edge_t       edge_s2;
	logic [15:0] is_s2, white_s2;

	always_comb begin
		ns_c   = xs_s1 >= {1'b0, HALF_STEPS};
		nc_c   = xc_s1 >= {1'b0, HALF_STEPS};
		xf_s   = ns_c ? 12'(xs_s1 - {1'b0, HALF_STEPS}) : xs_s1[11:0];
		xf_c   = nc_c ? 12'(xc_s1 - {1'b0, HALF_STEPS}) : xc_s1[11:0];
		is_div = div_ffff(prod_is_s1);
		wh_div = div_ffff(prod_wh_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ns_s2    <= ns_c;
			nc_s2    <= nc_c;
			p_s_s2   <= 22'(xf_s * (HALF_STEPS - xf_s));
			p_c_s2   <= 22'(xf_c * (HALF_STEPS - xf_c));
			edge_s2  <= edge_s1;
			is_s2    <= is_div[15:0];
			white_s2 <= wh_div[15:0];
		end
	end

	// stage 3: divider operands for sine and cosine
	logic [DIV_W-1:0] xs_s3, ds_s3, xc_s3, dc_s3;
	side_a_t          side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s3   <= DIV_W'({p_s_s2, 2'b00});
			xc_s3   <= DIV_W'({p_c_s2, 2'b00});
			ds_s3   <= DIV_W'(BHASK_DEN - {2'b00, p_s_s2});
			dc_s3   <= DIV_W'(BHASK_DEN - {2'b00, p_c_s2});
			side_s3 <= '{ns: ns_s2, nc: nc_s2, edge_sel: edge_s2, is: is_s2,
				white: white_s2};
		end
	end

	// sine and cosine dividers
	logic [Q_W-1:0] q_sin, q_cos;
	side_a_t        side_da_s [Q_W];

	htrcg_div u_div_sin (
		.clk      (clk),
		.en       (en),
		.dividend (xs_s3),
		.divisor  (ds_s3),
		.quotient (q_sin)
	);

	htrcg_div u_div_cos (
		.clk      (clk),
		.en       (en),
		.dividend (xc_s3),
		.divisor  (dc_s3),
		.quotient (q_cos)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_da_s[0] <= side_s3;
			for (int i = 1; i < Q_W; i++) begin
				side_da_s[i] <= side_da_s[i-1];
			end
		end
	end

	// stage e1: signed trig times edge constants
	side_a_t           side_a_out;
	logic signed [17:0] sv, cv;
	logic signed [32:0] su_e1, cpv_e1, cdv_e1, sdu_e1;
	edge_t              edge_e1;
	logic [15:0]        is_e1, white_e1;

	assign side_a_out = side_da_s[Q_W-1];

	always_comb begin
		sv = side_a_out.ns ? -$signed({1'b0, q_sin}) : $signed({1'b0, q_sin});
		cv = side_a_out.nc ? -$signed({1'b0, q_cos}) : $signed({1'b0, q_cos});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			su_e1    <= sv * PA_U[side_a_out.edge_sel];
			cpv_e1   <= cv * PA_V[side_a_out.edge_sel];
			cdv_e1   <= cv * ED_V[side_a_out.edge_sel];
			sdu_e1   <= sv * ED_U[side_a_out.edge_sel];
			edge_e1  <= side_a_out.edge_sel;
			is_e1    <= side_a_out.is;
			white_e1 <= side_a_out.white;
		end
	end

	// stage e2: numerator and denominator of the crossing
	logic signed [33:0] num_e2, den_e2;
	edge_t              edge_e2;
	logic [15:0]        is_e2, white_e2;

	always_ff @(posedge clk) begin
		if (en) begin
			num_e2   <= 34'(su_e1) - 34'(cpv_e1);
			den_e2   <= 34'(cdv_e1) - 34'(sdu_e1);
			edge_e2  <= edge_e1;
			is_e2    <= is_e1;
			white_e2 <= white_e1;
		end
	end

	// stage e3: clamp crossing off the edge, divider operands
	tcode_t           tcode_c;
	logic [DIV_W-1:0] xt_e3, dt_e3;
	side_b_t          side_e3;

	always_comb begin
		if (den_e2 <= 34'sd0 || num_e2 <= 34'sd0) begin
			tcode_c = T_ZERO;
		end else if (num_e2 >= den_e2) begin
			tcode_c = T_FULL;
		end else begin
			tcode_c = T_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xt_e3   <= num_e2[DIV_W-1:0];
			dt_e3   <= den_e2[DIV_W-1:0];
			side_e3 <= '{tcode: tcode_c, edge_sel: edge_e2, is: is_e2, white: white_e2};
		end
	end

	// crossing divider
	logic [Q_W-1:0] q_t;
	side_b_t        side_db_s [Q_W];

	htrcg_div u_div_t (
		.clk      (clk),
		.en       (en),
		.dividend (xt_e3),
		.divisor  (dt_e3),
		.quotient (q_t)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_db_s[0] <= side_e3;
			for (int i = 1; i < Q_W; i++) begin
				side_db_s[i] <= side_db_s[i-1];
			end
		end
	end

	// stage w1: edge weights and primary levels
	side_b_t     side_b_out;
	logic [16:0] t_val, wa, wr, wg, wb;
	logic [32:0] prod_r_w1, prod_g_w1, prod_b_w1;
	logic [15:0] white_w1;

	assign side_b_out = side_db_s[Q_W-1];

	always_comb begin
		case (side_b_out.tcode)
			T_FULL:  t_val = 17'd65536;
			T_ZERO:  t_val = 17'd0;
			default: t_val = q_t;
		endcase
		wa = 17'd65536 - t_val;
		case (side_b_out.edge_sel)
			EDGE_RG: begin
				wr = wa;
				wg = t_val;
				wb = 17'd0;
			end
			EDGE_GB: begin
				wr = 17'd0;
				wg = wa;
				wb = t_val;
			end
			EDGE_BR: begin
				wr = t_val;
				wg = 17'd0;
				wb = wa;
			end
			default: begin
				wr = 17'd0;
				wg = 17'd0;
				wb = 17'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_r_w1 <= 33'(side_b_out.is * wr);
			prod_g_w1 <= 33'(side_b_out.is * wg);
			prod_b_w1 <= 33'(side_b_out.is * wb);
			white_w1  <= side_b_out.white;
		end
	end

	// channel scaling, last stage is the output register
	logic [15:0] duty_r, duty_g, duty_b, duty_w;

	htrcg_chan u_chan_r (
		.clk   (clk),
		.en    (en),
		.level (prod_r_w1[31:16]),
		.gain  (red_gain_q),
		.fs    (fs),
		.duty  (duty_r)
	);

	htrcg_chan u_chan_g (
		.clk   (clk),
		.en    (en),
		.level (prod_g_w1[31:16]),
		.gain  (green_gain_q),
		.fs    (fs),
		.duty  (duty_g)
	);

	htrcg_chan u_chan_b (
		.clk   (clk),
		.en    (en),
		.level (prod_b_w1[31:16]),
		.gain  (blue_gain_q),
		.fs    (fs),
		.duty  (duty_b)
	);

	htrcg_chan u_chan_w (
		.clk   (clk),
		.en    (en),
		.level (white_w1),
		.gain  (white_gain_q),
		.fs    (fs),
		.duty  (duty_w)
	);

	assign rgbw = '{red_duty: duty_r, green_duty: duty_g, blue_duty: duty_b,
		white_duty: duty_w};

endmodule
